>>> design/tcpq_pkg.sv
package tcpq_pkg;

	// Fixed field widths
	localparam int AGE_W   = 7;
	localparam int TAG_W   = 16;
	localparam int CLASS_W = 2;

	// Defaults for the top-level parameters
	localparam int CLASS_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF    = 16;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Class codes (code 3 is unused and rejected on push)
	localparam logic [CLASS_W-1:0] CLS_HIGH = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_MID  = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_LOW  = 2'd2;

	// Positions of the classes in the store select vectors
	localparam int SEL_HIGH = 0;
	localparam int SEL_MID  = 1;
	localparam int SEL_LOW  = 2;

	// Result flags of one request, decided at accept time
	typedef struct packed {
		logic                pop_valid;
		logic [CLASS_W-1:0]  cls;
		logic                was_empty;
		logic                push_rejected;
	} res_t;

endpackage

>>> design/tcpq_ram.sv
module tcpq_ram import tcpq_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/tcpq_ctrl.sv
module tcpq_ctrl import tcpq_pkg::*; #(
	parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           opcode,
	input  logic [CLASS_W-1:0]             pclass,
	output logic [$clog2(CLASS_DEPTH)-1:0] addr,
	output logic [2:0]                     wr_sel,
	output logic [2:0]                     rd_sel,
	output res_t                           res
);

	localparam int IDX_W = $clog2(CLASS_DEPTH);
	localparam int CNT_W = $clog2(CLASS_DEPTH + 1);

	logic [CNT_W-1:0] high_count_q;
	logic [CNT_W-1:0] mid_count_q;
	logic [CNT_W-1:0] low_count_q;
	logic [IDX_W-1:0] mid_head_q;
	logic [IDX_W-1:0] low_head_q;

	logic             high_full, mid_full, low_full;
	logic [CNT_W-1:0] high_dec;
	logic [IDX_W:0]   mid_tail_sum, low_tail_sum, mid_next_sum, low_next_sum;
	logic [IDX_W-1:0] mid_tail, low_tail, mid_next, low_next;

	// Full flags and the top of the high stack
	assign high_full = (high_count_q == CNT_W'(CLASS_DEPTH));
	assign mid_full  = (mid_count_q == CNT_W'(CLASS_DEPTH));
	assign low_full  = (low_count_q == CNT_W'(CLASS_DEPTH));
	assign high_dec  = high_count_q - CNT_W'(1);

	// Tail slots of the circular buffers, wrapped once
	assign mid_tail_sum = {1'b0, mid_head_q} + (IDX_W+1)'(mid_count_q[IDX_W-1:0]);
	assign low_tail_sum = {1'b0, low_head_q} + (IDX_W+1)'(low_count_q[IDX_W-1:0]);
	assign mid_tail = (mid_tail_sum >= (IDX_W+1)'(CLASS_DEPTH)) ?
		IDX_W'(mid_tail_sum - (IDX_W+1)'(CLASS_DEPTH)) : mid_tail_sum[IDX_W-1:0];
	assign low_tail = (low_tail_sum >= (IDX_W+1)'(CLASS_DEPTH)) ?
		IDX_W'(low_tail_sum - (IDX_W+1)'(CLASS_DEPTH)) : low_tail_sum[IDX_W-1:0];

	// Heads after a pop, wrapped once
	assign mid_next_sum = {1'b0, mid_head_q} + (IDX_W+1)'(1);
	assign low_next_sum = {1'b0, low_head_q} + (IDX_W+1)'(1);
	assign mid_next = (mid_next_sum >= (IDX_W+1)'(CLASS_DEPTH)) ?
		IDX_W'(mid_next_sum - (IDX_W+1)'(CLASS_DEPTH)) : mid_next_sum[IDX_W-1:0];
	assign low_next = (low_next_sum >= (IDX_W+1)'(CLASS_DEPTH)) ?
		IDX_W'(low_next_sum - (IDX_W+1)'(CLASS_DEPTH)) : low_next_sum[IDX_W-1:0];

	// Decide the store access and the result flags of the request
	always_comb begin
		addr   = '0;
		wr_sel = '0;
		rd_sel = '0;
		res    = '0;
		if (opcode == OP_PUSH) begin
			case (pclass)
				CLS_HIGH: begin
					addr              = high_count_q[IDX_W-1:0];
					wr_sel[SEL_HIGH]  = accept && !high_full;
					res.push_rejected = high_full;
				end
				CLS_MID: begin
					addr              = mid_tail;
					wr_sel[SEL_MID]   = accept && !mid_full;
					res.push_rejected = mid_full;
				end
				CLS_LOW: begin
					addr              = low_tail;
					wr_sel[SEL_LOW]   = accept && !low_full;
					res.push_rejected = low_full;
				end
				default: begin
					res.push_rejected = 1'b1;
				end
			endcase
		end else if (high_count_q != '0) begin
			addr             = high_dec[IDX_W-1:0];
			rd_sel[SEL_HIGH] = accept;
			res.pop_valid    = 1'b1;
			res.cls          = CLS_HIGH;
		end else if (mid_count_q != '0) begin
			addr            = mid_head_q;
			rd_sel[SEL_MID] = accept;
			res.pop_valid   = 1'b1;
			res.cls         = CLS_MID;
		end else if (low_count_q != '0) begin
			addr            = low_head_q;
			rd_sel[SEL_LOW] = accept;
			res.pop_valid   = 1'b1;
			res.cls         = CLS_LOW;
		end else begin
			res.was_empty = 1'b1;
		end
	end

	// Advance counts and heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_count_q <= '0;
			mid_count_q  <= '0;
			low_count_q  <= '0;
			mid_head_q   <= '0;
			low_head_q   <= '0;
		end else begin
			if (wr_sel[SEL_HIGH]) begin
				high_count_q <= high_count_q + CNT_W'(1);
			end else if (rd_sel[SEL_HIGH]) begin
				high_count_q <= high_dec;
			end
			if (wr_sel[SEL_MID]) begin
				mid_count_q <= mid_count_q + CNT_W'(1);
			end else if (rd_sel[SEL_MID]) begin
				mid_count_q <= mid_count_q - CNT_W'(1);
				mid_head_q  <= mid_next;
			end
			if (wr_sel[SEL_LOW]) begin
				low_count_q <= low_count_q + CNT_W'(1);
			end else if (rd_sel[SEL_LOW]) begin
				low_count_q <= low_count_q - CNT_W'(1);
				low_head_q  <= low_next;
			end
		end
	end

	// At most one store is touched per request
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({wr_sel, rd_sel}))
		else $error("more than one store access in a cycle");

	// Counts never exceed the class depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		high_count_q <= CNT_W'(CLASS_DEPTH) && mid_count_q <= CNT_W'(CLASS_DEPTH)
		&& low_count_q <= CNT_W'(CLASS_DEPTH))
		else $error("class count beyond depth");

	// A high pop shrinks the stack by one
	a_high_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rd_sel[SEL_HIGH] |=> high_count_q == $past(high_dec))
		else $error("high count not decremented on pop");

endmodule

>>> design/three_class_priority_queue_unit.sv
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: age[6:0], entry_tag[22:7], zero[23]
//                tuser: opcode[0], priority_class[2:1]
// m_axis    out  tdata: out_age[6:0], out_tag[22:7], zero[23]
//                tuser: pop_valid[0], out_class[2:1], was_empty[3], push_rejected[4]
//
// One request per cycle while m_axis does not stall; each result passes
// through the registered read of the class stores, then the output register.
// Counts and heads are updated in the accept cycle, so back-to-back requests
// see each other's effects. arst_n clears counts, heads and valid flags; store
// contents are undefined until written. A stall on m_axis holds the result and
// the read stage, and s_axis_tready drops once both are full.
module three_class_priority_queue_unit import tcpq_pkg::*; #(
	parameter int CLASS_DEPTH = CLASS_DEPTH_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // age[6:0], entry_tag[22:7], zero[23]
	input  logic [2:0]  s_axis_tuser,  // opcode[0], priority_class[2:1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_age[6:0], out_tag[22:7], zero[23]
	output logic [4:0]  m_axis_tuser   // pop_valid, out_class[2:1], was_empty, push_rejected
);

	localparam int IDX_W  = $clog2(CLASS_DEPTH);
	localparam int KEEP_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int ENT_W  = AGE_W + KEEP_W;

	logic             accept;
	logic             advance;
	logic [IDX_W-1:0] addr;
	logic [2:0]       wr_sel, rd_sel;
	res_t             res;
	logic [ENT_W-1:0] wdata;
	logic [ENT_W-1:0] rdata [3];
	logic [ENT_W-1:0] ent_sel;

	logic             valid_s1;
	res_t             res_s1;
	logic             out_valid_q;
	logic [23:0]      out_data_q;
	logic [4:0]       out_user_q;

	// Handshakes: the read stage moves on when the output register frees up
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	tcpq_ctrl #(
		.CLASS_DEPTH(CLASS_DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.opcode (s_axis_tuser[0]),
		.pclass (s_axis_tuser[2:1]),
		.addr   (addr),
		.wr_sel (wr_sel),
		.rd_sel (rd_sel),
		.res    (res)
	);

	// Stored entry: kept tag bits above the age
	assign wdata = {s_axis_tdata[AGE_W+KEEP_W-1:AGE_W], s_axis_tdata[AGE_W-1:0]};

	// One store per class
	for (genvar c = 0; c < 3; c++) begin : g_store
		tcpq_ram #(
			.WIDTH(ENT_W),
			.DEPTH(CLASS_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_sel[c]),
			.waddr (addr),
			.wdata (wdata),
			.re    (rd_sel[c]),
			.raddr (addr),
			.rdata (rdata[c])
		);
	end

	// Pick the store that the popped class read
	always_comb begin
		case (res_s1.cls)
			CLS_HIGH: ent_sel = rdata[SEL_HIGH];
			CLS_MID:  ent_sel = rdata[SEL_MID];
			CLS_LOW:  ent_sel = rdata[SEL_LOW];
			default:  ent_sel = '0;
		endcase
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && !m_axis_tready);
		end
	end

	// Hold result flags with the read
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Load the output register; zero the entry fields unless a pop hit
	always_ff @(posedge clk) begin
		if (advance) begin
			out_user_q <= {res_s1.push_rejected, res_s1.was_empty, res_s1.cls,
				res_s1.pop_valid};
			if (res_s1.pop_valid) begin
				out_data_q <= {1'b0, TAG_W'(ent_sel[ENT_W-1:AGE_W]), ent_sel[AGE_W-1:0]};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Exactly one outcome flag at most per result
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0({m_axis_tuser[0], m_axis_tuser[3], m_axis_tuser[4]}))
		else $error("conflicting result flags");

	// Every store read lands in the read stage
	a_read_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_sel != '0) |=> valid_s1 && res_s1.pop_valid)
		else $error("store read without a pending pop");

endmodule
